[design/isim_pkg.sv]
// Shared types and constants for the interval set insert/merge block.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
`timescale 1ns / 1ps

package isim_pkg;

	// Field widths of the channels
	localparam int CMD_W   = 2;
	localparam int DATA_W  = 16;
	localparam int IDX_W   = 4;
	localparam int COUNT_W = 5;
	localparam int ENTRY_W = 2 * DATA_W;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	// Table read address select
	localparam logic [1:0] RD_I      = 2'd0;
	localparam logic [1:0] RD_K_PREV = 2'd1;
	localparam logic [1:0] RD_J      = 2'd2;
	localparam logic [1:0] RD_IDX    = 2'd3;

	// Table write select
	localparam logic [1:0] WR_NONE  = 2'd0;
	localparam logic [1:0] WR_K_RD  = 2'd1;
	localparam logic [1:0] WR_I_NEW = 2'd2;
	localparam logic [1:0] WR_I_CUR = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]         cmd;
		logic signed [DATA_W-1:0] range_begin;
		logic signed [DATA_W-1:0] range_end;
		logic [IDX_W-1:0]         entry_index;
	} item_t;

	typedef struct packed {
		logic [COUNT_W-1:0]       range_count;
		logic                     entry_valid;
		logic signed [DATA_W-1:0] entry_begin;
		logic signed [DATA_W-1:0] entry_end;
		logic                     overflow;
	} result_t;

	// Controller to datapath commands
	typedef struct packed {
		logic       load_item;
		logic       clear_cnt;
		logic       cnt_inc;
		logic       cnt_from_k;
		logic       i_inc;
		logic       j_from_i1;
		logic       j_inc;
		logic       k_from_cnt;
		logic       k_from_i1;
		logic       k_dec;
		logic       k_inc;
		logic       take_merge;
		logic       absorb;
		logic       set_ovf;
		logic       rd_en;
		logic [1:0] rd_sel;
		logic [1:0] wr_sel;
		logic       out_load;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic is_insert;
		logic is_clear;
		logic i_at_end;
		logic full;
		logic past_end;
		logic lies_below;
		logic widens;
		logic k_at_i;
		logic j_at_end;
		logic touches;
		logic idx_valid;
	} dp_sts_t;

endpackage

[design/isim_if.sv]
// Valid/ready channel interfaces: command items in, result items out.
// Depends on isim_pkg for field widths.
`timescale 1ns / 1ps

interface isim_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [isim_pkg::CMD_W-1:0]           cmd;
	logic signed [isim_pkg::DATA_W-1:0]   range_begin;
	logic signed [isim_pkg::DATA_W-1:0]   range_end;
	logic [isim_pkg::IDX_W-1:0]           entry_index;

	modport source(output valid, cmd, range_begin, range_end, entry_index, input ready);
	modport sink(input valid, cmd, range_begin, range_end, entry_index, output ready);
endinterface

interface isim_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic [isim_pkg::COUNT_W-1:0]         range_count;
	logic                                 entry_valid;
	logic signed [isim_pkg::DATA_W-1:0]   entry_begin;
	logic signed [isim_pkg::DATA_W-1:0]   entry_end;
	logic                                 overflow;

	modport source(output valid, range_count, entry_valid, entry_begin, entry_end, overflow,
		input ready);
	modport sink(input valid, range_count, entry_valid, entry_begin, entry_end, overflow,
		output ready);
endinterface

[design/isim_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module isim_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read, hold when idle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[design/isim_ctrl.sv]
// Sequencing state machine for the interval set: scan, shift, absorb, report.
// Depends on isim_pkg for the command and status structs.
`timescale 1ns / 1ps

module isim_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  isim_pkg::dp_sts_t dp_sts,
	output isim_pkg::dp_cmd_t dp_cmd
);

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_DISPATCH  = 4'd1;
	localparam logic [3:0] S_SCAN_RD   = 4'd2;
	localparam logic [3:0] S_SCAN_CHK  = 4'd3;
	localparam logic [3:0] S_PLACE     = 4'd4;
	localparam logic [3:0] S_SHIFT_RD  = 4'd5;
	localparam logic [3:0] S_SHIFT_WR  = 4'd6;
	localparam logic [3:0] S_ABS_RD    = 4'd7;
	localparam logic [3:0] S_ABS_CHK   = 4'd8;
	localparam logic [3:0] S_COPY_WR   = 4'd9;
	localparam logic [3:0] S_COPY_RD   = 4'd10;
	localparam logic [3:0] S_MERGE_END = 4'd11;
	localparam logic [3:0] S_OUT_RD    = 4'd12;
	localparam logic [3:0] S_OUT_LD    = 4'd13;

	logic [3:0] state_q;
	logic [3:0] state_nxt;
	logic       out_valid_q;

	// Next state and datapath commands
	always_comb begin
		dp_cmd    = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					dp_cmd.load_item = 1'b1;
					state_nxt = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (dp_sts.is_insert) begin
					state_nxt = S_SCAN_RD;
				end else if (dp_sts.is_clear) begin
					dp_cmd.clear_cnt = 1'b1;
					state_nxt = S_OUT_RD;
				end else begin
					state_nxt = S_OUT_RD;
				end
			end
			S_SCAN_RD: begin
				if (dp_sts.i_at_end) begin
					state_nxt = S_PLACE;
				end else begin
					dp_cmd.rd_en  = 1'b1;
					dp_cmd.rd_sel = isim_pkg::RD_I;
					state_nxt = S_SCAN_CHK;
				end
			end
			S_SCAN_CHK: begin
				if (dp_sts.past_end) begin
					dp_cmd.i_inc = 1'b1;
					state_nxt = S_SCAN_RD;
				end else if (dp_sts.lies_below) begin
					state_nxt = S_PLACE;
				end else if (dp_sts.widens) begin
					dp_cmd.take_merge = 1'b1;
					dp_cmd.j_from_i1  = 1'b1;
					dp_cmd.k_from_i1  = 1'b1;
					state_nxt = S_ABS_RD;
				end else begin
					state_nxt = S_OUT_RD;
				end
			end
			S_PLACE: begin
				if (dp_sts.full) begin
					dp_cmd.set_ovf = 1'b1;
					state_nxt = S_OUT_RD;
				end else begin
					dp_cmd.k_from_cnt = 1'b1;
					state_nxt = S_SHIFT_RD;
				end
			end
			S_SHIFT_RD: begin
				if (dp_sts.k_at_i) begin
					dp_cmd.wr_sel  = isim_pkg::WR_I_NEW;
					dp_cmd.cnt_inc = 1'b1;
					state_nxt = S_OUT_RD;
				end else begin
					dp_cmd.rd_en  = 1'b1;
					dp_cmd.rd_sel = isim_pkg::RD_K_PREV;
					state_nxt = S_SHIFT_WR;
				end
			end
			S_SHIFT_WR: begin
				dp_cmd.wr_sel = isim_pkg::WR_K_RD;
				dp_cmd.k_dec  = 1'b1;
				state_nxt = S_SHIFT_RD;
			end
			S_ABS_RD: begin
				if (dp_sts.j_at_end) begin
					state_nxt = S_MERGE_END;
				end else begin
					dp_cmd.rd_en  = 1'b1;
					dp_cmd.rd_sel = isim_pkg::RD_J;
					state_nxt = S_ABS_CHK;
				end
			end
			S_ABS_CHK: begin
				if (dp_sts.touches) begin
					dp_cmd.absorb = 1'b1;
					dp_cmd.j_inc  = 1'b1;
					state_nxt = S_ABS_RD;
				end else begin
					state_nxt = S_COPY_WR;
				end
			end
			S_COPY_WR: begin
				dp_cmd.wr_sel = isim_pkg::WR_K_RD;
				dp_cmd.k_inc  = 1'b1;
				dp_cmd.j_inc  = 1'b1;
				state_nxt = S_COPY_RD;
			end
			S_COPY_RD: begin
				if (dp_sts.j_at_end) begin
					state_nxt = S_MERGE_END;
				end else begin
					dp_cmd.rd_en  = 1'b1;
					dp_cmd.rd_sel = isim_pkg::RD_J;
					state_nxt = S_COPY_WR;
				end
			end
			S_MERGE_END: begin
				dp_cmd.wr_sel     = isim_pkg::WR_I_CUR;
				dp_cmd.cnt_from_k = 1'b1;
				state_nxt = S_OUT_RD;
			end
			S_OUT_RD: begin
				dp_cmd.rd_en  = dp_sts.idx_valid;
				dp_cmd.rd_sel = isim_pkg::RD_IDX;
				state_nxt = S_OUT_LD;
			end
			S_OUT_LD: begin
				// Hold until the output register is free
				if (!out_valid_q || rsp_ready) begin
					dp_cmd.out_load = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// State and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (dp_cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;

endmodule

[design/isim_dp.sv]
// Datapath for the interval set: range table RAM, scan/shift/merge pointers,
// count, compares and the result register. Depends on isim_pkg and isim_ram.
`timescale 1ns / 1ps

module isim_dp #(
	parameter int MAX_RANGES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  isim_pkg::item_t   item,
	input  isim_pkg::dp_cmd_t dp_cmd,
	output isim_pkg::dp_sts_t dp_sts,
	output isim_pkg::result_t result
);

	localparam int CW = $clog2(MAX_RANGES + 1);
	localparam int AW = $clog2(MAX_RANGES);
	localparam int IW = (CW > isim_pkg::IDX_W) ? CW : isim_pkg::IDX_W;
	localparam int DW = isim_pkg::DATA_W;

	logic [isim_pkg::CMD_W-1:0] cmd_q;
	logic signed [DW-1:0]       b_q;
	logic signed [DW-1:0]       e_q;
	logic [isim_pkg::IDX_W-1:0] idx_q;
	logic [CW-1:0]              cnt_q;
	logic [CW-1:0]              i_q;
	logic [CW-1:0]              j_q;
	logic [CW-1:0]              k_q;
	logic signed [DW-1:0]       cur_b_q;
	logic signed [DW-1:0]       cur_e_q;
	logic                       ovf_q;
	isim_pkg::result_t          result_q;

	logic                           wr_en;
	logic [AW-1:0]                  wr_addr;
	logic [isim_pkg::ENTRY_W-1:0]   wr_data;
	logic [AW-1:0]                  rd_addr;
	logic [isim_pkg::ENTRY_W-1:0]   rd_data;
	logic signed [DW-1:0]           rd_b;
	logic signed [DW-1:0]           rd_e;
	logic [IW-1:0]                  idx_x;
	logic [IW-1:0]                  cnt_x;
	logic                           idx_valid;

	// Range table: begin in the upper half, end in the lower half
	isim_ram #(
		.WIDTH(isim_pkg::ENTRY_W),
		.DEPTH(MAX_RANGES)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (dp_cmd.rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign rd_b = rd_data[isim_pkg::ENTRY_W-1:DW];
	assign rd_e = rd_data[DW-1:0];

	assign idx_x     = IW'(idx_q);
	assign cnt_x     = IW'(cnt_q);
	assign idx_valid = (idx_x < cnt_x);

	// Read address select
	always_comb begin
		case (dp_cmd.rd_sel)
			isim_pkg::RD_I:      rd_addr = AW'(i_q);
			isim_pkg::RD_K_PREV: rd_addr = AW'(k_q - 1'b1);
			isim_pkg::RD_J:      rd_addr = AW'(j_q);
			isim_pkg::RD_IDX:    rd_addr = AW'(idx_x);
			default:             rd_addr = AW'(i_q);
		endcase
	end

	// Write address and data select
	always_comb begin
		wr_en   = 1'b1;
		wr_addr = AW'(i_q);
		wr_data = {cur_b_q, cur_e_q};
		case (dp_cmd.wr_sel)
			isim_pkg::WR_NONE: begin
				wr_en = 1'b0;
			end
			isim_pkg::WR_K_RD: begin
				wr_addr = AW'(k_q);
				wr_data = rd_data;
			end
			isim_pkg::WR_I_NEW: begin
				wr_data = {b_q, e_q};
			end
			isim_pkg::WR_I_CUR: begin
				wr_data = {cur_b_q, cur_e_q};
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Status back to the controller
	assign dp_sts.is_insert  = (cmd_q == isim_pkg::CMD_INSERT);
	assign dp_sts.is_clear   = (cmd_q == isim_pkg::CMD_CLEAR);
	assign dp_sts.i_at_end   = (i_q == cnt_q);
	assign dp_sts.full       = (cnt_q == CW'(MAX_RANGES));
	assign dp_sts.past_end   = (b_q > rd_e);
	assign dp_sts.lies_below = (e_q < rd_b);
	assign dp_sts.widens     = (b_q < rd_b) || (e_q > rd_e);
	assign dp_sts.k_at_i     = (k_q == i_q);
	assign dp_sts.j_at_end   = (j_q == cnt_q);
	assign dp_sts.touches    = (cur_e_q >= rd_b);
	assign dp_sts.idx_valid  = idx_valid;

	// Count, pointers and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			i_q   <= '0;
			j_q   <= '0;
			k_q   <= '0;
			ovf_q <= 1'b0;
		end else begin
			if (dp_cmd.load_item) begin
				i_q   <= '0;
				ovf_q <= 1'b0;
			end else if (dp_cmd.i_inc) begin
				i_q <= i_q + 1'b1;
			end
			if (dp_cmd.set_ovf) begin
				ovf_q <= 1'b1;
			end
			if (dp_cmd.clear_cnt) begin
				cnt_q <= '0;
			end else if (dp_cmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (dp_cmd.cnt_from_k) begin
				cnt_q <= k_q;
			end
			if (dp_cmd.j_from_i1) begin
				j_q <= i_q + 1'b1;
			end else if (dp_cmd.j_inc) begin
				j_q <= j_q + 1'b1;
			end
			if (dp_cmd.k_from_cnt) begin
				k_q <= cnt_q;
			end else if (dp_cmd.k_from_i1) begin
				k_q <= i_q + 1'b1;
			end else if (dp_cmd.k_dec) begin
				k_q <= k_q - 1'b1;
			end else if (dp_cmd.k_inc) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	// Item fields, merged range and result payload
	always_ff @(posedge clk) begin
		if (dp_cmd.load_item) begin
			cmd_q <= item.cmd;
			b_q   <= item.range_begin;
			e_q   <= item.range_end;
			idx_q <= item.entry_index;
		end
		if (dp_cmd.take_merge) begin
			cur_b_q <= (b_q < rd_b) ? b_q : rd_b;
			cur_e_q <= (e_q > rd_e) ? e_q : rd_e;
		end else if (dp_cmd.absorb) begin
			cur_e_q <= (rd_e > cur_e_q) ? rd_e : cur_e_q;
		end
		if (dp_cmd.out_load) begin
			result_q.range_count <= isim_pkg::COUNT_W'(cnt_q);
			result_q.entry_valid <= idx_valid;
			result_q.entry_begin <= idx_valid ? rd_b : '0;
			result_q.entry_end   <= idx_valid ? rd_e : '0;
			result_q.overflow    <= ovf_q;
		end
	end

	assign result = result_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_RANGES))
		else $error("range count above table depth");

	a_ovf_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.set_ovf |-> (cnt_q == CW'(MAX_RANGES)))
		else $error("overflow flagged with free entries");

	a_grow_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.cnt_inc |-> (cnt_q < CW'(MAX_RANGES)))
		else $error("count grown past table depth");

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (CW'(wr_addr) < CW'(MAX_RANGES)))
		else $error("table write beyond depth");

	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.out_load && (cmd_q == isim_pkg::CMD_CLEAR))
		|=> (result_q.range_count == '0) && !result_q.entry_valid)
		else $error("clear did not report an empty set");

endmodule

[design/interval_set_insert_merge.sv]
// Sorted set of disjoint signed 16-bit ranges that merges overlapping ranges on insert.
// Each command item returns one result item with the count and the entry at entry_index.
// A read or clear passes the dispatch, output read and output load states to reach the
// output register, and the block takes a new item the cycle after that. An insert
// reads and compares each stored range it scans past, reads and writes each range
// it moves up to make room, and reads then compares or writes each range it absorbs
// or moves down after a merge. The table sits in one RAM with one read and one write
// port and a registered read, and every entry step is a read followed by a compare
// or a write. One item is processed at a time; a finished result waits in the output
// register while the next item is accepted. No clearing pass after reset.
// Depends on isim_pkg, isim_if, isim_ram, isim_ctrl and isim_dp.
`timescale 1ns / 1ps

module interval_set_insert_merge #(
	parameter int MAX_RANGES = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	isim_req_if.sink   req,
	isim_rsp_if.source rsp
);

	isim_pkg::item_t   item;
	isim_pkg::result_t result;
	isim_pkg::dp_cmd_t dp_cmd;
	isim_pkg::dp_sts_t dp_sts;

	// Gather the input item fields
	assign item.cmd         = req.cmd;
	assign item.range_begin = req.range_begin;
	assign item.range_end   = req.range_end;
	assign item.entry_index = req.entry_index;

	isim_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.dp_sts   (dp_sts),
		.dp_cmd   (dp_cmd)
	);

	isim_dp #(
		.MAX_RANGES(MAX_RANGES)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.dp_cmd(dp_cmd),
		.dp_sts(dp_sts),
		.result(result)
	);

	// Drive the result item fields
	assign rsp.range_count = result.range_count;
	assign rsp.entry_valid = result.entry_valid;
	assign rsp.entry_begin = result.entry_begin;
	assign rsp.entry_end   = result.entry_end;
	assign rsp.overflow    = result.overflow;

endmodule
